// File: hdl/complex_arithmetic_unit_assert.svh
// assertion macros for the complex arithmetic unit checker
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define CAU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define CAU_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/cau_pkg.sv
// types, widths and codes shared by the complex arithmetic unit
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;

   // derived widths
   localparam int PW = 2 * DATA_WIDTH;          // products, squares, magnitudes
   localparam int SW = PW + 2;                  // signed sums of products
   localparam int NW = PW + FRAC_BITS;          // scaled dividend
   localparam int QW = DATA_WIDTH + 1;          // quotient bits kept
   localparam logic [PW:0] HALF_LSB =
      (FRAC_BITS > 0) ? (PW + 1)'(1) << (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0) : '0;
   localparam logic [QW:0] MAX_POS = (QW + 1)'((1 << (DATA_WIDTH - 1)) - 1);
   localparam logic [QW:0] MAX_NEG = (QW + 1)'(1 << (DATA_WIDTH - 1));
   localparam logic signed [DATA_WIDTH-1:0] SAT_HI = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] SAT_LO = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam int DIV_STEPS = QW;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_MUL  = 2'd1,
      OP_DIV  = 2'd2,
      OP_CONJ = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_SAT      = 2'd2
   } status_type;

   typedef struct packed {
      op_type                        operation;
      logic signed [DATA_WIDTH-1:0]  z_re;
      logic signed [DATA_WIDTH-1:0]  z_im;
      logic signed [DATA_WIDTH-1:0]  w_re;
      logic signed [DATA_WIDTH-1:0]  w_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  result_re;
      logic signed [DATA_WIDTH-1:0]  result_im;
      status_type                    status;
   } rsp_type;

   // item as it travels through the divider steps
   typedef struct packed {
      logic          is_div;
      logic          div_zero;
      logic          neg_re;
      logic          neg_im;
      logic          ovf_re;
      logic          ovf_im;
      logic [QW-1:0] q_re;
      logic [QW-1:0] q_im;
      logic [PW-1:0] rem_re;
      logic [PW-1:0] rem_im;
      logic [QW-1:0] nlo_re;
      logic [QW-1:0] nlo_im;
      logic [PW-1:0] den;
   } work_type;

endpackage

// File: hdl/cau_front.sv
// front end: products, sums to sign and magnitude, divider set-up
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cau_pkg::req_type  req_payload,
   output logic              out_valid,
   input  logic              out_ready,
   output cau_pkg::work_type out_work
);

   typedef struct packed {
      cau_pkg::op_type                       op;
      logic signed [cau_pkg::DATA_WIDTH-1:0] z_re;
      logic signed [cau_pkg::DATA_WIDTH-1:0] z_im;
      logic signed [cau_pkg::DATA_WIDTH-1:0] w_re;
      logic signed [cau_pkg::DATA_WIDTH-1:0] w_im;
      logic signed [cau_pkg::PW-1:0]         p_rr;
      logic signed [cau_pkg::PW-1:0]         p_ii;
      logic signed [cau_pkg::PW-1:0]         p_ri;
      logic signed [cau_pkg::PW-1:0]         p_ir;
      logic        [cau_pkg::PW-1:0]         sq_r;
      logic        [cau_pkg::PW-1:0]         sq_i;
   } prod_type;

   typedef struct packed {
      cau_pkg::op_type         op;
      logic                    neg_re;
      logic                    neg_im;
      logic [cau_pkg::PW-1:0]  mag_re;
      logic [cau_pkg::PW-1:0]  mag_im;
      logic [cau_pkg::PW-1:0]  den;
   } sum_type;

   logic              v1_ff, v2_ff, v3_ff;
   logic              v1_in, v2_in, v3_in;
   logic              rdy1, rdy2, rdy3;
   prod_type          s1_ff, s1_in;
   sum_type           s2_ff, s2_in;
   cau_pkg::work_type s3_ff, s3_in;

   // ready chain, collapses bubbles
   assign rdy3      = !v3_ff || out_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign v1_in     = rdy1 ? req_valid : v1_ff;
   assign v2_in     = rdy2 ? v1_ff : v2_ff;
   assign v3_in     = rdy3 ? v2_ff : v3_ff;

   // stage 1: the six products
   always_comb begin
      logic signed [cau_pkg::PW-1:0] zr, zi, wr, wi, sr, si;
      zr = cau_pkg::PW'(req_payload.z_re);
      zi = cau_pkg::PW'(req_payload.z_im);
      wr = cau_pkg::PW'(req_payload.w_re);
      wi = cau_pkg::PW'(req_payload.w_im);
      s1_in.op   = req_payload.operation;
      s1_in.z_re = req_payload.z_re;
      s1_in.z_im = req_payload.z_im;
      s1_in.w_re = req_payload.w_re;
      s1_in.w_im = req_payload.w_im;
      s1_in.p_rr = zr * wr;
      s1_in.p_ii = zi * wi;
      s1_in.p_ri = zr * wi;
      s1_in.p_ir = zi * wr;
      sr = wr * wr;
      si = wi * wi;
      s1_in.sq_r = sr;
      s1_in.sq_i = si;
   end

   // stage 2: operation sums and sign/magnitude split
   always_comb begin
      logic signed [cau_pkg::SW-1:0] a_re, a_im;
      logic signed [cau_pkg::SW-1:0] zr, zi, wr, wi, rr, ii, ri, ir;
      zr = cau_pkg::SW'(s1_ff.z_re);
      zi = cau_pkg::SW'(s1_ff.z_im);
      wr = cau_pkg::SW'(s1_ff.w_re);
      wi = cau_pkg::SW'(s1_ff.w_im);
      rr = cau_pkg::SW'(s1_ff.p_rr);
      ii = cau_pkg::SW'(s1_ff.p_ii);
      ri = cau_pkg::SW'(s1_ff.p_ri);
      ir = cau_pkg::SW'(s1_ff.p_ir);
      unique case (s1_ff.op)
         cau_pkg::OP_ADD: begin
            a_re = zr + wr;
            a_im = zi + wi;
         end
         cau_pkg::OP_MUL: begin
            a_re = rr - ii;
            a_im = ri + ir;
         end
         cau_pkg::OP_DIV: begin
            a_re = rr + ii;
            a_im = ir - ri;
         end
         default: begin
            a_re = zr;
            a_im = -zi;
         end
      endcase
      s2_in.op     = s1_ff.op;
      s2_in.neg_re = a_re < 0;
      s2_in.neg_im = a_im < 0;
      s2_in.mag_re = (a_re < 0) ? cau_pkg::PW'(-a_re) : cau_pkg::PW'(a_re);
      s2_in.mag_im = (a_im < 0) ? cau_pkg::PW'(-a_im) : cau_pkg::PW'(a_im);
      s2_in.den    = s1_ff.sq_r + s1_ff.sq_i;
   end

   // stage 3: product rounding, or dividend scaling and overflow check
   always_comb begin
      logic [cau_pkg::NW-1:0] n_re, n_im, hi_re, hi_im, den_x;
      logic [cau_pkg::PW:0]   m_re, m_im;
      n_re  = {s2_ff.mag_re, {cau_pkg::FRAC_BITS{1'b0}}};
      n_im  = {s2_ff.mag_im, {cau_pkg::FRAC_BITS{1'b0}}};
      hi_re = n_re >> cau_pkg::QW;
      hi_im = n_im >> cau_pkg::QW;
      den_x = cau_pkg::NW'(s2_ff.den);
      if (s2_ff.op == cau_pkg::OP_MUL) begin
         m_re = ({1'b0, s2_ff.mag_re} + cau_pkg::HALF_LSB) >> cau_pkg::FRAC_BITS;
         m_im = ({1'b0, s2_ff.mag_im} + cau_pkg::HALF_LSB) >> cau_pkg::FRAC_BITS;
      end else begin
         m_re = {1'b0, s2_ff.mag_re};
         m_im = {1'b0, s2_ff.mag_im};
      end
      s3_in.is_div   = s2_ff.op == cau_pkg::OP_DIV;
      s3_in.div_zero = s2_ff.den == '0;
      s3_in.neg_re   = s2_ff.neg_re;
      s3_in.neg_im   = s2_ff.neg_im;
      s3_in.den      = s2_ff.den;
      s3_in.rem_re   = cau_pkg::PW'(hi_re);
      s3_in.rem_im   = cau_pkg::PW'(hi_im);
      s3_in.nlo_re   = n_re[cau_pkg::QW-1:0];
      s3_in.nlo_im   = n_im[cau_pkg::QW-1:0];
      if (s2_ff.op == cau_pkg::OP_DIV) begin
         s3_in.ovf_re = hi_re >= den_x;
         s3_in.ovf_im = hi_im >= den_x;
         s3_in.q_re   = '0;
         s3_in.q_im   = '0;
      end else begin
         s3_in.ovf_re = (m_re >> cau_pkg::QW) != '0;
         s3_in.ovf_im = (m_im >> cau_pkg::QW) != '0;
         s3_in.q_re   = m_re[cau_pkg::QW-1:0];
         s3_in.q_im   = m_im[cau_pkg::QW-1:0];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
      if (rdy3) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_work  = s3_ff;

endmodule

// File: hdl/cau_div_step.sv
// one restoring division step for both quotient parts
module cau_div_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cau_pkg::work_type in_work,
   output logic              out_valid,
   input  logic              out_ready,
   output cau_pkg::work_type out_work
);

   logic              valid_ff, valid_in;
   cau_pkg::work_type work_ff, work_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // shift in the next dividend bit, subtract the divisor where it fits
   always_comb begin
      logic [cau_pkg::PW:0] sh_re, sh_im, den_x;
      logic                 ge_re, ge_im;
      den_x   = {1'b0, in_work.den};
      sh_re   = {in_work.rem_re, in_work.nlo_re[cau_pkg::QW-1]};
      sh_im   = {in_work.rem_im, in_work.nlo_im[cau_pkg::QW-1]};
      ge_re   = sh_re >= den_x;
      ge_im   = sh_im >= den_x;
      work_in = in_work;
      if (in_work.is_div) begin
         work_in.rem_re = cau_pkg::PW'(ge_re ? sh_re - den_x : sh_re);
         work_in.rem_im = cau_pkg::PW'(ge_im ? sh_im - den_x : sh_im);
         work_in.q_re   = {in_work.q_re[cau_pkg::QW-2:0], ge_re};
         work_in.q_im   = {in_work.q_im[cau_pkg::QW-2:0], ge_im};
         work_in.nlo_re = {in_work.nlo_re[cau_pkg::QW-2:0], 1'b0};
         work_in.nlo_im = {in_work.nlo_im[cau_pkg::QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// File: hdl/complex_arithmetic_unit.sv
// top level of the complex arithmetic unit
//
//  port group   direction  handshake              contents
//  req_*        in         req_valid / req_ready  operation, z and w in Q8.8
//  rsp_*        out        rsp_valid / rsp_ready  result parts in Q8.8, status
//
// a request passes three front stages (products, sums, divider set-up),
// 17 division steps and one rounding and saturation stage on its way to
// the response; one request per cycle enters when nothing stalls.
// every operation takes the same path, so responses leave in request order.
// each stage holds its own valid bit and fills empty slots while the output waits.
// reset clears all valid bits at the clock edge, leaving the pipeline empty.
module complex_arithmetic_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cau_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cau_pkg::rsp_type  rsp_payload
);

   logic              st_valid [cau_pkg::DIV_STEPS+1];
   logic              st_ready [cau_pkg::DIV_STEPS+1];
   cau_pkg::work_type st_work  [cau_pkg::DIV_STEPS+1];

   logic              rsp_valid_ff, rsp_valid_in;
   cau_pkg::rsp_type  rsp_payload_ff, rsp_payload_in;
   logic              out_ready;

   // front end
   cau_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .out_valid   (st_valid[0]),
      .out_ready   (st_ready[0]),
      .out_work    (st_work[0])
   );

   // division steps, one quotient bit each
   for (genvar i = 0; i < cau_pkg::DIV_STEPS; i++) begin : g_step
      cau_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[i]),
         .in_ready  (st_ready[i]),
         .in_work   (st_work[i]),
         .out_valid (st_valid[i+1]),
         .out_ready (st_ready[i+1]),
         .out_work  (st_work[i+1])
      );
   end

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign st_ready[cau_pkg::DIV_STEPS] = out_ready;
   assign rsp_valid_in = out_ready ? st_valid[cau_pkg::DIV_STEPS] : rsp_valid_ff;

   // final rounding, saturation and status
   always_comb begin
      cau_pkg::work_type         w;
      logic [cau_pkg::QW:0]      r_re, r_im;
      logic                      up_re, up_im, sat_re, sat_im;
      logic [cau_pkg::PW:0]      den_x;
      w      = st_work[cau_pkg::DIV_STEPS];
      den_x  = {1'b0, w.den};
      up_re  = w.is_div && ({w.rem_re, 1'b0} >= den_x);
      up_im  = w.is_div && ({w.rem_im, 1'b0} >= den_x);
      r_re   = {1'b0, w.q_re} + (cau_pkg::QW + 1)'(up_re);
      r_im   = {1'b0, w.q_im} + (cau_pkg::QW + 1)'(up_im);
      sat_re = w.ovf_re || (w.neg_re ? r_re > cau_pkg::MAX_NEG : r_re > cau_pkg::MAX_POS);
      sat_im = w.ovf_im || (w.neg_im ? r_im > cau_pkg::MAX_NEG : r_im > cau_pkg::MAX_POS);
      if (sat_re) begin
         rsp_payload_in.result_re = w.neg_re ? cau_pkg::SAT_LO : cau_pkg::SAT_HI;
      end else if (w.neg_re) begin
         rsp_payload_in.result_re = -cau_pkg::DATA_WIDTH'(r_re);
      end else begin
         rsp_payload_in.result_re = cau_pkg::DATA_WIDTH'(r_re);
      end
      if (sat_im) begin
         rsp_payload_in.result_im = w.neg_im ? cau_pkg::SAT_LO : cau_pkg::SAT_HI;
      end else if (w.neg_im) begin
         rsp_payload_in.result_im = -cau_pkg::DATA_WIDTH'(r_im);
      end else begin
         rsp_payload_in.result_im = cau_pkg::DATA_WIDTH'(r_im);
      end
      rsp_payload_in.status = (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      // zero divisor overrides everything
      if (w.is_div && w.div_zero) begin
         rsp_payload_in.result_re = '0;
         rsp_payload_in.result_im = '0;
         rsp_payload_in.status    = cau_pkg::ST_DIV_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: hdl/cau_checker.sv
// port-level checks for the complex arithmetic unit, bound to the top level
`include "complex_arithmetic_unit_assert.svh"

module cau_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cau_pkg::rsp_type rsp_payload
);

   // pipeline comes out of reset empty
   `CAU_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid, "response valid right after reset")

   // a stalled response holds
   `CAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled response changed")

   // zero divisor gives a zero result
   `CAU_ASSERT_SAME(a_div_zero, rsp_valid && rsp_payload.status == cau_pkg::ST_DIV_ZERO, rsp_payload.result_re == '0 && rsp_payload.result_im == '0, "divide by zero with nonzero result")

   // saturation shows a limit value in some part
   `CAU_ASSERT_SAME(a_sat_limit, rsp_valid && rsp_payload.status == cau_pkg::ST_SAT, rsp_payload.result_re == cau_pkg::SAT_HI || rsp_payload.result_re == cau_pkg::SAT_LO || rsp_payload.result_im == cau_pkg::SAT_HI || rsp_payload.result_im == cau_pkg::SAT_LO, "saturated status without a limit value")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

// File: sim/tb_complex_arithmetic_unit.sv
// self-checking testbench for the complex arithmetic unit
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit;
   import cau_pkg::*;

   localparam int N_RANDOM = 1450;
   localparam int DRAIN_CYCLES = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   rsp_type pending_results[$];
   int      error_count = 0;
   bit      stimulus_done = 1'b0;

   // directed row: request, typed-in result and whether it is used
   typedef struct {
      req_type req;
      rsp_type rsp;
      bit      fixed;
   } row_type;

   row_type directed[$];

   complex_arithmetic_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #20ms;
      $display("tb_complex_arithmetic_unit: done, errors");
      $finish;
   end

   // saturate a signed magnitude pair to one part
   function automatic logic [DATA_WIDTH-1:0] clamp_part(input bit neg, input longint unsigned mag,
                                                        inout bit sat);
      longint unsigned lim;
      lim = 64'd1 << (DATA_WIDTH - 1);
      if (!neg) begin
         if (mag > lim - 1) begin
            mag = lim - 1;
            sat = 1'b1;
         end
         return mag[DATA_WIDTH-1:0];
      end
      if (mag > lim) begin
         mag = lim;
         sat = 1'b1;
      end
      return DATA_WIDTH'(-mag);
   endfunction

   // rounded quotient num * 2^FRAC_BITS / den, capped beyond range
   function automatic longint unsigned rounded_quotient(input longint unsigned num,
                                                        input longint unsigned den);
      longint unsigned cap, q, r;
      cap = 64'd1 << DATA_WIDTH;
      q = num / den;
      r = num % den;
      if (q > cap) return cap + 1;
      for (int i = 0; i < FRAC_BITS; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= den) begin
            q = q | 1;
            r = r - den;
         end
         if (q > cap) return cap + 1;
      end
      if ((r << 1) >= den) q++;
      return q;
   endfunction

   // expected result of one request
   function automatic rsp_type complex_result(input req_type rq);
      longint zr, zi, wr, wi, sre, sim;
      longint unsigned mre, mim, den, half;
      bit nre, nim, sat;
      rsp_type rs;
      zr = rq.z_re; zi = rq.z_im; wr = rq.w_re; wi = rq.w_im;
      sat = 1'b0;
      half = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 0;
      case (rq.operation)
         OP_ADD: begin
            sre = zr + wr;
            sim = zi + wi;
         end
         OP_MUL: begin
            sre = zr * wr - zi * wi;
            sim = zr * wi + zi * wr;
         end
         OP_DIV: begin
            sre = zr * wr + zi * wi;
            sim = zi * wr - zr * wi;
         end
         default: begin
            sre = zr;
            sim = -zi;
         end
      endcase
      nre = sre < 0;
      nim = sim < 0;
      mre = nre ? -sre : sre;
      mim = nim ? -sim : sim;
      if (rq.operation == OP_MUL) begin
         mre = (mre + half) >> FRAC_BITS;
         mim = (mim + half) >> FRAC_BITS;
      end else if (rq.operation == OP_DIV) begin
         den = wr * wr + wi * wi;
         if (den == 0) begin
            rs.result_re = '0;
            rs.result_im = '0;
            rs.status = ST_DIV_ZERO;
            return rs;
         end
         mre = rounded_quotient(mre, den);
         mim = rounded_quotient(mim, den);
      end
      rs.result_re = clamp_part(nre, mre, sat);
      rs.result_im = clamp_part(nim, mim, sat);
      rs.status = sat ? ST_SAT : ST_OK;
      return rs;
   endfunction

   function automatic req_type make_req(input op_type op, input int zr, input int zi,
                                        input int wr, input int wi);
      req_type r;
      r.operation = op;
      r.z_re = DATA_WIDTH'(zr); r.z_im = DATA_WIDTH'(zi);
      r.w_re = DATA_WIDTH'(wr); r.w_im = DATA_WIDTH'(wi);
      return r;
   endfunction

   task automatic add_row(input req_type rq, input bit fixed, input int rre = 0,
                          input int rim = 0, input status_type st = ST_OK);
      row_type row;
      row.req = rq;
      row.fixed = fixed;
      row.rsp.result_re = DATA_WIDTH'(rre);
      row.rsp.result_im = DATA_WIDTH'(rim);
      row.rsp.status = st;
      directed.push_back(row);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, want %0d", what, got, want);
      error_count++;
   endtask

   // random operand part, often near the extremes or small
   function automatic int pick_part();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32767 : -32768;
         1: return int'($urandom_range(0, 1023)) - 512;
         2: return 0;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // send one request, waiting for acceptance
   task automatic send_request(input req_type rq, input rsp_type want);
      req_valid <= 1'b1;
      req_payload <= rq;
      pending_results.push_back(want);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_cycles(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // stimulus
   initial begin
      req_type rq;
      int burst;
      add_row(make_req(OP_ADD, 0, 0, 0, 0), 1, 0, 0, ST_OK);
      add_row(make_req(OP_ADD, 32767, 32767, 1, 1), 1, 32767, 32767, ST_SAT);
      add_row(make_req(OP_ADD, -32768, -32768, -1, -1), 1, -32768, -32768, ST_SAT);
      add_row(make_req(OP_ADD, 32767, -32768, -32768, 32767), 1, -1, -1, ST_OK);
      add_row(make_req(OP_MUL, 256, 0, 256, 0), 1, 256, 0, ST_OK);
      add_row(make_req(OP_MUL, 0, 256, 0, 256), 1, -256, 0, ST_OK);
      add_row(make_req(OP_MUL, 32767, 32767, 32767, 32767), 1, 0, 32767, ST_SAT);
      add_row(make_req(OP_MUL, -32768, -32768, -32768, -32768), 1, 0, 32767, ST_SAT);
      add_row(make_req(OP_MUL, 1, 0, 128, 0), 0);
      add_row(make_req(OP_MUL, -1, 0, 128, 0), 0);
      add_row(make_req(OP_DIV, 1234, -77, 0, 0), 1, 0, 0, ST_DIV_ZERO);
      add_row(make_req(OP_DIV, -32768, -32768, 0, 0), 1, 0, 0, ST_DIV_ZERO);
      add_row(make_req(OP_DIV, 256, 256, 256, 0), 1, 256, 256, ST_OK);
      add_row(make_req(OP_DIV, 32767, -32768, 1, 0), 1, 32767, -32768, ST_SAT);
      add_row(make_req(OP_DIV, -32768, 32767, -32768, -32768), 0);
      add_row(make_req(OP_DIV, 100, 3, 7, -9), 0);
      add_row(make_req(OP_DIV, 32767, 32767, 32767, 32767), 0);
      add_row(make_req(OP_CONJ, 100, -200, 5, 5), 1, 100, 200, ST_OK);
      add_row(make_req(OP_CONJ, -32768, -32768, 0, 0), 1, -32768, 32767, ST_SAT);
      add_row(make_req(OP_CONJ, 32767, 32767, -1, -1), 1, 32767, -32767, ST_OK);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed[i])
         send_request(directed[i].req,
                      directed[i].fixed ? directed[i].rsp : complex_result(directed[i].req));

      // hold off until the pipeline has drained
      idle_cycles(1);
      while (pending_results.size() != 0) @(posedge clock);

      // random bursts with gaps
      for (int n = 0; n < N_RANDOM; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
            rq.operation = op_type'($urandom_range(0, 3));
            rq.z_re = DATA_WIDTH'(pick_part()); rq.z_im = DATA_WIDTH'(pick_part());
            rq.w_re = DATA_WIDTH'(pick_part()); rq.w_im = DATA_WIDTH'(pick_part());
            if ($urandom_range(0, 15) == 0) begin
               rq.w_re = '0;
               rq.w_im = '0;
            end
            send_request(rq, complex_result(rq));
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
      end
      req_valid <= 1'b0;
      stimulus_done <= 1'b1;
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (($urandom_range(0, 255) < 32)) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // response checking
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("unexpected response");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.result_re !== want.result_re)
               report_mismatch("result_re", rsp_payload.result_re, want.result_re);
            if (rsp_payload.result_im !== want.result_im)
               report_mismatch("result_im", rsp_payload.result_im, want.result_im);
            if (rsp_payload.status !== want.status)
               report_mismatch("status", rsp_payload.status, want.status);
         end
      end
   end

   // end of run
   initial begin
      wait (stimulus_done);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("tb_complex_arithmetic_unit: done, clean");
      else
         $display("tb_complex_arithmetic_unit: done, errors");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hdl
hdl/cau_pkg.sv
hdl/cau_front.sv
hdl/cau_div_step.sv
hdl/complex_arithmetic_unit.sv
hdl/cau_checker.sv
sim/tb_complex_arithmetic_unit.sv
